// ===== rtl/core/bgb_pkg.sv =====
// bgb_pkg: shared constants, codes and helpers for the glyph blitter.
// No dependencies; imported by bitmap_glyph_blitter and tb_top.
package bgb_pkg;

	localparam int CODES     = 256;
	localparam int CODE_W    = 8;
	localparam int PEN_W     = 14;
	localparam int MASK_W    = 64;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 13;

	// operation codes
	localparam logic [1:0] OP_DRAW     = 2'd0;
	localparam logic [1:0] OP_LOAD_MET = 2'd1;
	localparam logic [1:0] OP_LOAD_BMP = 2'd2;
	localparam logic [1:0] OP_NOP      = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT  = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEFT     = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_TOP      = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_RIGHT    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_BOTTOM   = 4'd7;

	localparam logic [7:0] BYTE_ALL = 8'hff;
	localparam logic [2:0] BIT_SEL  = 3'h7;

	// saturate a 16-bit signed value to the 14-bit pen range
	function automatic logic signed [PEN_W-1:0] sat14(input logic signed [15:0] v);
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		lo = -16'sd8192;
		hi = 16'sd8191;
		if (v < lo)
			return lo[PEN_W-1:0];
		else if (v > hi)
			return hi[PEN_W-1:0];
		else
			return v[PEN_W-1:0];
	endfunction

	function automatic logic [MASK_W-1:0] ones64(input logic [7:0] n);
		logic [MASK_W-1:0] one;
		one = MASK_W'(1);
		if (n >= 8'd64)
			return '1;
		else
			return (one << n[5:0]) - one;
	endfunction

endpackage

// ===== rtl/core/bgb_ifs.sv =====
// bgb_ifs: valid/ready channel interfaces for input items and row results.
// No dependencies.
interface bgb_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [7:0]         code;
	logic               new_string;
	logic signed [12:0] start_x;
	logic signed [12:0] start_y;
	logic               solid;
	logic [15:0]        fg_color;
	logic [15:0]        bg_color;
	logic [14:0]        load_addr;
	logic [17:0]        load_data;

	modport source(output valid, operation, code, new_string, start_x, start_y, solid,
		fg_color, bg_color, load_addr, load_data, input ready);
	modport sink(input valid, operation, code, new_string, start_x, start_y, solid,
		fg_color, bg_color, load_addr, load_data, output ready);
endinterface

interface bgb_result_if;
	logic               valid;
	logic               ready;
	logic signed [13:0] row_y;
	logic signed [13:0] span_x;
	logic [63:0]        write_mask;
	logic [63:0]        fg_mask;
	logic [15:0]        fg_color_res;
	logic [15:0]        bg_color_res;
	logic               last;
	logic               error;

	modport source(output valid, row_y, span_x, write_mask, fg_mask, fg_color_res,
		bg_color_res, last, error, input ready);
	modport sink(input valid, row_y, span_x, write_mask, fg_mask, fg_color_res,
		bg_color_res, last, error, output ready);
endinterface

// ===== rtl/core/bgb_ram.sv =====
// bgb_ram: single-clock memory, one write port and one registered read port.
// No dependencies.
module bgb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/bitmap_glyph_blitter.sv =====
// bitmap_glyph_blitter: top level; sequencer, pen, clipping and result register.
// Depends on bgb_pkg, bgb_ifs (bgb_item_if, bgb_result_if) and bgb_ram.
//
// Usage: input words arrive on "item" (valid/ready). A load word (metrics entry
// or bitmap byte) answers with one result word; a draw word answers with one
// result word per glyph row, or one empty word for an out-of-range code or a
// zero height. Operation 3 is taken and dropped. Results leave on "result"
// through an output register, so a new input word is taken while the previous
// last result still waits for the receiver.
// Sequence: a metrics load or an out-of-range draw goes from acceptance to its
// result, a bitmap byte load first through address reduction before the write,
// a zero-height draw through the metrics fetch. A draw works through metrics
// fetch and address setup (two multiplies and the modulo reduction of the
// bitmap base), then per row fetches ceil(width/8) bytes through the bitmap
// memory's single read port, one byte a cycle. One word is in work at a time.
// A receiver stall holds the sequencer at the row it is about to emit.
// Reset clears the pen, the registers to their defaults and the control state;
// both memories hold garbage until loaded. Configuration is written through
// cfg_we/cfg_index/cfg_data while idle.
module bitmap_glyph_blitter #(
	parameter int MAX_HEIGHT   = 32,
	parameter int BITMAP_BYTES = 32768,
	parameter int MAX_SPAN     = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [bgb_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bgb_pkg::CFG_DAT_W-1:0] cfg_data,
	bgb_item_if.sink                 item,
	bgb_result_if.source             result
);
	import bgb_pkg::*;

	localparam int AW  = $clog2(BITMAP_BYTES);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int A_W = 12 + HW;                 // width of glyph base offset
	localparam int MW  = A_W + AW + 1;
	localparam longint RECIP = (64'd1 << A_W) / BITMAP_BYTES;
	localparam int RW  = A_W + 1;                 // reciprocal width
	localparam logic [AW:0] BB = (AW+1)'(BITMAP_BYTES);
	localparam logic [HW-1:0] HMAX = HW'(MAX_HEIGHT);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_MET   = 9'b000000010,
		ST_BASE  = 9'b000000100,
		ST_RED1  = 9'b000001000,
		ST_RED2  = 9'b000010000,
		ST_RED3  = 9'b000100000,
		ST_FETCH = 9'b001000000,
		ST_ROW   = 9'b010000000,
		ST_EMPTY = 9'b100000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0]  first_code_q, last_code_q;
	logic [5:0]  glyph_height_q;
	logic [3:0]  bytes_per_row_q;
	logic [11:0] clip_left_q, clip_top_q;
	logic [12:0] clip_right_q, clip_bottom_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_code_q    <= 8'd32;
			last_code_q     <= 8'd127;
			glyph_height_q  <= 6'd16;
			bytes_per_row_q <= 4'd1;
			clip_left_q     <= '0;
			clip_top_q      <= '0;
			clip_right_q    <= 13'd4096;
			clip_bottom_q   <= 13'd4096;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FIRST_CODE:    first_code_q    <= cfg_data[7:0];
				REG_LAST_CODE:     last_code_q     <= cfg_data[7:0];
				REG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data[5:0];
				REG_BYTES_PER_ROW: bytes_per_row_q <= cfg_data[3:0];
				REG_CLIP_LEFT:     clip_left_q     <= cfg_data[11:0];
				REG_CLIP_TOP:      clip_top_q      <= cfg_data[11:0];
				REG_CLIP_RIGHT:    clip_right_q    <= cfg_data;
				REG_CLIP_BOTTOM:   clip_bottom_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched word
	logic [1:0]  op_q;
	logic [7:0]  code_off_q;
	logic        solid_q;
	logic [15:0] fg_q, bg_q;
	logic [7:0]  bdata_q;
	logic        err_q, adv_q;
	logic [HW-1:0] h_q;

	logic signed [PEN_W-1:0] pen_x_q, pen_y_q;

	// metrics of the glyph in work
	logic [5:0] lead_q, wid_q;
	logic [7:0] total_q;
	logic [3:0] nbytes_q;
	logic [11:0] prod1_q;
	logic [A_W-1:0] red_a_q;
	logic [A_W+RW-1:0] prod_q;
	logic [AW:0] r_q;
	logic [MASK_W-1:0] colmask_q, g_q;

	// row walker
	logic [AW-1:0] row_addr_q;
	logic [HW-1:0] row_i_q;
	logic [3:0]    issue_k_q;
	logic          rd_v_s1;
	logic [2:0]    k_s1;

	// handshake
	logic accept, out_free, emit;
	assign item.ready = (state_q == ST_IDLE);
	assign accept     = item.valid && item.ready;
	assign out_free   = !result.valid || result.ready;
	assign emit       = out_free && (state_q == ST_ROW || state_q == ST_EMPTY);

	// metrics memory
	logic [5:0]  ld_lead, ld_wid, ld_trail;
	logic [7:0]  ld_sum;
	logic        ld_err;
	logic        met_we, met_re;
	logic [17:0] met_rdata;

	assign ld_lead  = item.load_data[17:12];
	assign ld_wid   = item.load_data[11:6];
	assign ld_trail = item.load_data[5:0];
	assign ld_sum   = 8'(ld_lead) + 8'(ld_wid) + 8'(ld_trail);
	assign ld_err   = ld_sum > 8'(MAX_SPAN);
	assign met_we   = accept && item.operation == OP_LOAD_MET && !ld_err;
	assign met_re   = accept && item.operation == OP_DRAW;

	bgb_ram #(.WIDTH(18), .DEPTH(CODES)) u_metrics (
		.clk   (clk),
		.we    (met_we),
		.waddr (item.load_addr[CODE_W-1:0]),
		.wdata (item.load_data),
		.re    (met_re),
		.raddr (item.code),
		.rdata (met_rdata)
	);

	// bitmap memory and address arithmetic
	logic [A_W-1:0] q_est;
	logic [MW-1:0]  r_full;
	logic [AW-1:0]  r_mod;
	logic [AW:0]    byte_sum, row_sum;
	logic [AW-1:0]  byte_addr, row_next;
	logic           bmp_we, bmp_re;
	logic [7:0]     bmp_rdata;

	assign q_est   = prod_q[A_W +: A_W];
	assign r_full  = MW'(red_a_q) - MW'(q_est) * MW'(BB);
	assign r_mod   = (r_q >= BB) ? AW'(r_q - BB) : r_q[AW-1:0];
	assign byte_sum = {1'b0, row_addr_q} + (AW+1)'(issue_k_q[2:0]);
	assign byte_addr = (byte_sum >= BB) ? AW'(byte_sum - BB) : byte_sum[AW-1:0];
	assign row_sum  = {1'b0, row_addr_q} + (AW+1)'(bytes_per_row_q);
	assign row_next = (row_sum >= BB) ? AW'(row_sum - BB) : row_sum[AW-1:0];
	assign bmp_we   = (state_q == ST_RED3) && op_q == OP_LOAD_BMP;
	assign bmp_re   = (state_q == ST_FETCH) && issue_k_q != nbytes_q;

	bgb_ram #(.WIDTH(8), .DEPTH(BITMAP_BYTES)) u_bitmap (
		.clk   (clk),
		.we    (bmp_we),
		.waddr (r_mod),
		.wdata (bdata_q),
		.re    (bmp_re),
		.raddr (byte_addr),
		.rdata (bmp_rdata)
	);

	// glyph byte placement: keep pixels below width, shift to lead + 8k
	logic [5:0] remb;
	logic [7:0] bm;
	logic [6:0] sh;
	assign remb = wid_q - {k_s1, 3'b000};
	assign bm   = bmp_rdata & ((remb >= 6'd8) ? BYTE_ALL :
		8'((9'd1 << remb[2:0]) - 9'd1));
	assign sh   = 7'(lead_q) + {1'b0, k_s1, 3'b000};

	// column clip, per pixel of the span
	logic [MASK_W-1:0] colmask_d;
	always_comb begin
		logic signed [15:0] x;
		for (int k = 0; k < MASK_W; k++) begin
			x = 16'(pen_x_q) + 16'(k);
			colmask_d[k] = (x >= $signed({4'b0, clip_left_q})) &&
				(x < $signed({3'b0, clip_right_q})) && (8'(k) < total_q);
		end
	end

	// row result
	logic signed [15:0] y_full;
	logic               row_vis, row_last;
	logic [MASK_W-1:0]  wr_row;
	assign y_full   = 16'(pen_y_q) + 16'(row_i_q);
	assign row_vis  = (y_full >= $signed({4'b0, clip_top_q})) &&
		(y_full < $signed({3'b0, clip_bottom_q}));
	assign row_last = (row_i_q + HW'(1)) == h_q;
	assign wr_row   = row_vis ? ((solid_q ? ones64(total_q) : g_q) & colmask_q) : '0;

	logic signed [PEN_W-1:0] pen_adv;
	assign pen_adv = sat14(16'(pen_x_q) + 16'(total_q));

	logic [HW:0] h_cfg;
	assign h_cfg = (HW+1)'(glyph_height_q);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pen_x_q   <= '0;
			pen_y_q   <= '0;
			rd_v_s1   <= 1'b0;
			issue_k_q <= '0;
			result.valid <= 1'b0;
		end else begin
			rd_v_s1 <= bmp_re;
			if (emit)
				result.valid <= 1'b1;
			else if (result.ready)
				result.valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (item.operation)
							OP_DRAW: begin
								if (item.new_string) begin
									pen_x_q <= PEN_W'(item.start_x);
									pen_y_q <= PEN_W'(item.start_y);
								end
								if (item.code < first_code_q || item.code > last_code_q)
									state_q <= ST_EMPTY;
								else
									state_q <= ST_MET;
							end
							OP_LOAD_MET: state_q <= ST_EMPTY;
							OP_LOAD_BMP: state_q <= ST_RED1;
							default: ;
						endcase
					end
				end
				ST_MET:  state_q <= ST_BASE;
				ST_BASE: state_q <= (h_q == '0) ? ST_EMPTY : ST_RED1;
				ST_RED1: state_q <= ST_RED2;
				ST_RED2: state_q <= ST_RED3;
				ST_RED3: begin
					issue_k_q <= '0;
					state_q   <= (op_q == OP_LOAD_BMP) ? ST_EMPTY : ST_FETCH;
				end
				ST_FETCH: begin
					if (bmp_re)
						issue_k_q <= issue_k_q + 4'd1;
					else if (!rd_v_s1)
						state_q <= ST_ROW;
				end
				ST_ROW: begin
					if (out_free) begin
						issue_k_q    <= '0;
						if (row_last) begin
							pen_x_q <= pen_adv;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FETCH;
						end
					end
				end
				ST_EMPTY: begin
					if (out_free) begin
						if (adv_q)
							pen_x_q <= pen_adv;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= item.operation;
			code_off_q <= item.code - first_code_q;
			solid_q    <= item.solid;
			fg_q       <= item.fg_color;
			bdata_q    <= item.load_data[7:0];
			bg_q       <= item.bg_color;
			err_q      <= item.operation == OP_LOAD_MET && ld_err;
			adv_q      <= 1'b0;
			h_q        <= (h_cfg > (HW+1)'(MAX_HEIGHT)) ? HMAX : HW'(glyph_height_q);
			red_a_q    <= A_W'(item.load_addr);
		end
		if (state_q == ST_MET) begin
			lead_q   <= met_rdata[17:12];
			wid_q    <= met_rdata[11:6];
			total_q  <= 8'(met_rdata[17:12]) + 8'(met_rdata[11:6]) + 8'(met_rdata[5:0]);
			nbytes_q <= 4'((7'(met_rdata[11:6]) + 7'd7) >> 3);
			prod1_q  <= 12'(code_off_q) * 12'(bytes_per_row_q);
		end
		if (state_q == ST_BASE) begin
			colmask_q <= colmask_d;
			red_a_q   <= A_W'(prod1_q) * A_W'(h_q);
			adv_q     <= (h_q == '0);
		end
		if (state_q == ST_RED1)
			prod_q <= (A_W+RW)'(red_a_q) * (A_W+RW)'(RW'(RECIP));
		if (state_q == ST_RED2)
			r_q <= r_full[AW:0];
		if (state_q == ST_RED3) begin
			row_addr_q <= r_mod;
			row_i_q    <= '0;
			g_q        <= '0;
		end
		if (rd_v_s1)
			g_q <= g_q | (MASK_W'(bm) << sh);
		if (bmp_re)
			k_s1 <= issue_k_q[2:0];
		if (state_q == ST_ROW && out_free && !row_last) begin
			row_i_q    <= row_i_q + HW'(1);
			row_addr_q <= row_next;
			g_q        <= '0;
		end
		if (state_q == ST_ROW && out_free) begin
			result.row_y      <= sat14(y_full);
			result.span_x     <= pen_x_q;
			result.write_mask <= wr_row;
			result.fg_mask    <= wr_row & g_q;
			result.fg_color_res <= fg_q;
			result.bg_color_res <= bg_q;
			result.last       <= row_last;
			result.error      <= 1'b0;
		end
		if (state_q == ST_EMPTY && out_free) begin
			result.row_y      <= pen_y_q;
			result.span_x     <= pen_x_q;
			result.write_mask <= '0;
			result.fg_mask    <= '0;
			result.fg_color_res <= fg_q;
			result.bg_color_res <= bg_q;
			result.last       <= 1'b1;
			result.error      <= err_q;
		end
	end

`ifndef ASSERT_OFF
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> state_q == ST_IDLE)
		else $error("input taken outside idle");
	a_fetch_data: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q == ST_FETCH))
		else $error("bitmap data returned outside row fetch");
	a_met_span: assert property (@(posedge clk) disable iff (!arst_n)
		met_we |-> ld_sum <= 8'(MAX_SPAN))
		else $error("metrics entry wider than span written");
`endif
endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for bitmap_glyph_blitter.
// Depends on bgb_pkg, bgb_ifs and the rtl/core sources of the blitter.
`timescale 1ns / 1ps

module tb_top;
	import bgb_pkg::*;

	localparam int BMP_BYTES = 32768;
	localparam int HMAX      = 32;
	localparam int SPAN_MAX  = 64;
	localparam int STALL_CAP = 4000;   // cycles with no word moving on either side
	localparam int HOLD_LEN  = 400;    // long receiver hold-off

	typedef struct {
		logic [1:0]         op;
		logic [7:0]         code;
		logic               ns;
		logic signed [12:0] sx;
		logic signed [12:0] sy;
		logic               solid;
		logic [15:0]        fgc;
		logic [15:0]        bgc;
		logic [14:0]        addr;
		logic [17:0]        data;
	} glyph_word_t;

	typedef struct {
		logic signed [13:0] row_y;
		logic signed [13:0] span_x;
		logic [63:0]        wmask;
		logic [63:0]        fmask;
		logic [15:0]        fgc;
		logic [15:0]        bgc;
		logic               last;
		logic               err;
	} row_word_t;

	typedef struct {
		glyph_word_t w;
		bit          typed;
		int          ey;
		int          ex;
		bit          eerr;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	bgb_item_if   itm();
	bgb_result_if res();

	bitmap_glyph_blitter dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.item(itm), .result(res)
	);

	// Predictor state: registers, pen and both stores, plus written flags so
	// that no draw ever reads an entry the block has not been given.
	int first_code, last_code, height, bpr;
	int clip_l, clip_t, clip_r, clip_b;
	int pen_x, pen_y;
	logic [17:0] met[CODES];
	logic [7:0]  bmp[BMP_BYTES];
	bit          met_ok[CODES];
	bit          bmp_ok[BMP_BYTES];

	row_word_t rows_due[$];
	int last_n;

	int fails, n_draw, n_load, n_rows, n_err;
	int snd_pct, rcv_pct;
	bit hold_req;
	int hold_left;
	int quiet;

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		itm.valid = 1'b0;
		itm.operation = OP_DRAW;
		itm.code = '0; itm.new_string = 1'b0; itm.start_x = '0; itm.start_y = '0;
		itm.solid = 1'b0; itm.fg_color = '0; itm.bg_color = '0;
		itm.load_addr = '0; itm.load_data = '0;
		res.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic int sat_pen(input longint v);
		if (v < -8192) return -8192;
		if (v > 8191) return 8191;
		return int'(v);
	endfunction

	function automatic logic [63:0] span_ones(input int n);
		if (n >= 64) return '1;
		return (64'd1 << n) - 64'd1;
	endfunction

	function automatic void push_row(input int y, input int x, input logic [63:0] wr,
			input logic [63:0] fg, input glyph_word_t w, input bit lst, input bit err);
		row_word_t r;
		r.row_y = y[13:0];
		r.span_x = x[13:0];
		r.wmask = wr;
		r.fmask = fg;
		r.fgc = w.fgc;
		r.bgc = w.bgc;
		r.last = lst;
		r.err = err;
		rows_due.push_back(r);
	endfunction

	// Expected rows for one accepted word; returns how many were queued.
	function automatic int predict_rows(input glyph_word_t w);
		int lead, wid, trail, total, h, base, a, pos, sum;
		longint x, y;
		logic [63:0] g, wr, col;
		bit err;
		if (w.op == OP_NOP) return 0;
		if (w.op == OP_LOAD_MET) begin
			sum = int'(w.data[17:12]) + int'(w.data[11:6]) + int'(w.data[5:0]);
			err = sum > SPAN_MAX;
			if (!err) begin
				met[w.addr[7:0]] = w.data;
				met_ok[w.addr[7:0]] = 1'b1;
			end
			push_row(pen_y, pen_x, '0, '0, w, 1'b1, err);
			return 1;
		end
		if (w.op == OP_LOAD_BMP) begin
			bmp[w.addr] = w.data[7:0];
			bmp_ok[w.addr] = 1'b1;
			push_row(pen_y, pen_x, '0, '0, w, 1'b1, 1'b0);
			return 1;
		end
		if (w.ns) begin
			pen_x = int'(w.sx);
			pen_y = int'(w.sy);
		end
		if (int'(w.code) < first_code || int'(w.code) > last_code) begin
			push_row(pen_y, pen_x, '0, '0, w, 1'b1, 1'b0);
			return 1;
		end
		lead  = int'(met[w.code][17:12]);
		wid   = int'(met[w.code][11:6]);
		trail = int'(met[w.code][5:0]);
		total = lead + wid + trail;
		h = (height > HMAX) ? HMAX : height;
		base = (int'(w.code) - first_code) * bpr * h;
		col = '0;
		for (int k = 0; k < total && k < 64; k++) begin
			x = longint'(pen_x) + k;
			if (x >= clip_l && x < clip_r) col[k] = 1'b1;
		end
		for (int i = 0; i < h; i++) begin
			y = longint'(pen_y) + i;
			g = '0;
			for (int j = 0; j < wid; j++) begin
				a = (base + i * bpr + (j >> 3)) % BMP_BYTES;
				pos = lead + j;
				if (pos < 64 && bmp[a][j & BIT_SEL]) g[pos] = 1'b1;
			end
			wr = w.solid ? span_ones(total) : g;
			if (y < clip_t || y >= clip_b) wr = '0;
			wr &= col;
			push_row(sat_pen(y), pen_x, wr, g & wr, w, i == h - 1, 1'b0);
		end
		// zero height: one empty word at the pen before it moves
		if (h == 0)
			push_row(pen_y, pen_x, '0, '0, w, 1'b1, 1'b0);
		pen_x = sat_pen(longint'(pen_x) + total);
		return (h == 0) ? 1 : h;
	endfunction

	// Every store entry this code's draw reads under the current registers is known.
	function automatic bit glyph_ready(input int c);
		int wid, h, base, nb;
		if (!met_ok[c]) return 1'b0;
		wid = int'(met[c][11:6]);
		h = (height > HMAX) ? HMAX : height;
		base = (c - first_code) * bpr * h;
		nb = (wid + 7) / 8;
		for (int i = 0; i < h; i++)
			for (int b = 0; b < nb; b++)
				if (!bmp_ok[(base + i * bpr + b) % BMP_BYTES]) return 1'b0;
		return 1'b1;
	endfunction

	// sender: optional idle cycles, then hold the word until it is taken
	task automatic send(input glyph_word_t w);
		if (snd_pct > 0 && $urandom_range(99) < snd_pct) begin
			itm.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < snd_pct);
		end
		itm.valid      <= 1'b1;
		itm.operation  <= w.op;
		itm.code       <= w.code;
		itm.new_string <= w.ns;
		itm.start_x    <= w.sx;
		itm.start_y    <= w.sy;
		itm.solid      <= w.solid;
		itm.fg_color   <= w.fgc;
		itm.bg_color   <= w.bgc;
		itm.load_addr  <= w.addr;
		itm.load_data  <= w.data;
		do @(posedge clk); while (!itm.ready);
		last_n = predict_rows(w);
		if (w.op == OP_DRAW) n_draw++;
		else if (w.op != OP_NOP) n_load++;
	endtask

	function automatic glyph_word_t rand_word(input logic [1:0] op);
		glyph_word_t w;
		w.op = op;
		w.code = 8'($urandom);
		w.ns = 1'($urandom);
		w.sx = 13'($urandom);
		w.sy = 13'($urandom);
		w.solid = 1'($urandom);
		w.fgc = 16'($urandom);
		w.bgc = 16'($urandom);
		w.addr = 15'($urandom);
		w.data = 18'($urandom);
		return w;
	endfunction

	// Give a code a legal metrics entry if it has none, then every missing byte.
	task automatic define_glyph(input int c);
		glyph_word_t w;
		int lead, wid, trail, h, base, nb, a;
		if (!met_ok[c]) begin
			lead = $urandom_range(0, 8);
			wid = ($urandom_range(9) == 0) ? $urandom_range(24, 56) :
				$urandom_range(0, 12);
			if (lead + wid > SPAN_MAX) wid = SPAN_MAX - lead;
			trail = $urandom_range(0, (SPAN_MAX - lead - wid) < 8 ? SPAN_MAX - lead - wid : 8);
			w = rand_word(OP_LOAD_MET);
			w.addr[7:0] = c[7:0];
			w.data = {6'(lead), 6'(wid), 6'(trail)};
			send(w);
		end
		wid = int'(met[c][11:6]);
		h = (height > HMAX) ? HMAX : height;
		base = (c - first_code) * bpr * h;
		nb = (wid + 7) / 8;
		for (int i = 0; i < h; i++)
			for (int b = 0; b < nb; b++) begin
				a = (base + i * bpr + b) % BMP_BYTES;
				if (!bmp_ok[a]) begin
					w = rand_word(OP_LOAD_BMP);
					w.addr = 15'(a);
					send(w);
				end
			end
	endtask

	// block idle: nothing due, valid low, then a wait for a dropped word in flight
	task automatic settle();
		itm.valid <= 1'b0;
		wait (rows_due.size() == 0);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_regs(input int v[8]);
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= CFG_IDX_W'(i);
			cfg_data  <= CFG_DAT_W'(v[i]);
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		first_code = v[REG_FIRST_CODE] & 8'hff;
		last_code  = v[REG_LAST_CODE] & 8'hff;
		height     = v[REG_GLYPH_HEIGHT] & 6'h3f;
		bpr        = v[REG_BYTES_PER_ROW] & 4'hf;
		clip_l     = v[REG_CLIP_LEFT] & 12'hfff;
		clip_t     = v[REG_CLIP_TOP] & 12'hfff;
		clip_r     = v[REG_CLIP_RIGHT] & 13'h1fff;
		clip_b     = v[REG_CLIP_BOTTOM] & 13'h1fff;
	endtask

	// receiver: random stalls, plus one long hold-off counted here
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_LEN;
			hold_req = 1'b0;
		end
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			res.ready <= 1'b0;
		end else begin
			res.ready <= ($urandom_range(99) >= rcv_pct);
		end
	end

	// result checker: oldest expectation first, field by field
	always @(posedge clk) begin
		row_word_t e;
		if (arst_n && res.valid && res.ready) begin
			if (rows_due.size() == 0) begin
				$error("result word with nothing expected: row_y=%0d span_x=%0d",
					res.row_y, res.span_x);
				fails++;
			end else begin
				e = rows_due.pop_front();
				n_rows++;
				if (res.error) n_err++;
				if (res.row_y !== e.row_y) begin
					$error("row_y exp %0d got %0d", e.row_y, res.row_y); fails++;
				end
				if (res.span_x !== e.span_x) begin
					$error("span_x exp %0d got %0d", e.span_x, res.span_x); fails++;
				end
				if (res.write_mask !== e.wmask) begin
					$error("write_mask exp %h got %h", e.wmask, res.write_mask); fails++;
				end
				if (res.fg_mask !== e.fmask) begin
					$error("fg_mask exp %h got %h", e.fmask, res.fg_mask); fails++;
				end
				if (res.fg_color_res !== e.fgc) begin
					$error("fg_color_res exp %h got %h", e.fgc, res.fg_color_res); fails++;
				end
				if (res.bg_color_res !== e.bgc) begin
					$error("bg_color_res exp %h got %h", e.bgc, res.bg_color_res); fails++;
				end
				if (res.last !== e.last) begin
					$error("last exp %b got %b", e.last, res.last); fails++;
				end
				if (res.error !== e.err) begin
					$error("error exp %b got %b", e.err, res.error); fails++;
				end
			end
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if ((itm.valid && itm.ready) || (res.valid && res.ready) || !arst_n)
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_CAP) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic add_dir(ref dir_row_t q[$], input logic [1:0] op, input int c,
			input bit ns, input int sx, input int sy, input bit solid,
			input int addr, input int data, input bit typed, input int ey,
			input int ex, input bit eerr);
		dir_row_t r;
		r.w = rand_word(op);
		r.w.code = 8'(c); r.w.ns = ns; r.w.sx = 13'(sx); r.w.sy = 13'(sy);
		r.w.solid = solid; r.w.addr = 15'(addr); r.w.data = 18'(data);
		r.typed = typed; r.ey = ey; r.ex = ex; r.eerr = eerr;
		q.push_back(r);
	endtask

	initial begin
		dir_row_t dir_q[$];
		row_word_t t;
		glyph_word_t w;
		int cfg[8];
		int c, n_phase, r;

		first_code = 32; last_code = 127; height = 16; bpr = 1;
		clip_l = 0; clip_t = 0; clip_r = 4096; clip_b = 4096;
		pen_x = 0; pen_y = 0;
		fails = 0; n_draw = 0; n_load = 0; n_rows = 0; n_err = 0;
		snd_pct = 0; rcv_pct = 0; hold_req = 1'b0; hold_left = 0; quiet = 0;

		// Directed words under reset registers. Width-zero glyphs keep the
		// bitmap out of play so only lead/trail painting and clipping show.
		add_dir(dir_q, OP_DRAW, 0, 0, 0, 0, 1, 0, 0, 1, 0, 0, 0);          // below first
		add_dir(dir_q, OP_DRAW, 255, 1, -4096, 4095, 1, 0, 0, 1, 4095, -4096, 0);
		add_dir(dir_q, OP_NOP, 65, 1, 5, 5, 1, 0, 0, 0, 0, 0, 0);          // dropped
		add_dir(dir_q, OP_LOAD_MET, 0, 0, 0, 0, 0, 32, 'h3f041, 1, 4095, -4096, 1);
		add_dir(dir_q, OP_LOAD_MET, 0, 0, 0, 0, 0, 32, 'h3f001, 1, 4095, -4096, 0);
		add_dir(dir_q, OP_LOAD_MET, 0, 0, 0, 0, 0, 'h7f7f, 'h02003, 1, 4095, -4096, 0);
		add_dir(dir_q, OP_LOAD_BMP, 0, 0, 0, 0, 0, 'h7fff, 'h3ffff, 1, 4095, -4096, 0);
		add_dir(dir_q, OP_LOAD_BMP, 0, 0, 0, 0, 0, 0, 0, 1, 4095, -4096, 0);
		add_dir(dir_q, OP_DRAW, 32, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0);
		add_dir(dir_q, OP_DRAW, 32, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		add_dir(dir_q, OP_DRAW, 127, 1, 4095, -4096, 1, 0, 0, 0, 0, 0, 0);
		add_dir(dir_q, OP_DRAW, 127, 1, -4096, 4090, 1, 0, 0, 0, 0, 0, 0);
		add_dir(dir_q, OP_DRAW, 127, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0);
		add_dir(dir_q, OP_DRAW, 128, 0, 0, 0, 1, 0, 0, 1, 4090, -4086, 0);   // above last

		@(posedge clk);
		wait (arst_n);
		@(posedge clk);
		foreach (dir_q[i]) begin
			send(dir_q[i].w);
			if (dir_q[i].typed) begin
				repeat (last_n) void'(rows_due.pop_back());
				t.row_y = dir_q[i].ey[13:0]; t.span_x = dir_q[i].ex[13:0];
				t.wmask = '0; t.fmask = '0;
				t.fgc = dir_q[i].w.fgc; t.bgc = dir_q[i].w.bgc;
				t.last = 1'b1; t.err = dir_q[i].eerr;
				rows_due.push_back(t);
			end
		end
		itm.valid <= 1'b0;

		// Register phases; idling cycles through none / sender / receiver / both.
		for (int p = 0; p < 8; p++) begin
			settle();
			case (p)
				0: cfg = '{0, 255, 1, 1, 0, 0, 4096, 4096};
				1: cfg = '{65, 90, 4, 2, 100, 50, 300, 200};
				2: cfg = '{10, 5, 3, 1, 0, 0, 4096, 4096};
				3: cfg = '{48, 57, 0, 1, 7, 9, 4000, 4090};
				4: cfg = '{32, 33, 63, 1, 4095, 4095, 4096, 4096};
				5: cfg = '{0, 255, 2, 1, 0, 0, 0, 0};
				default: begin
					cfg[0] = $urandom_range(0, 200);
					cfg[1] = cfg[0] + $urandom_range(0, 55);
					cfg[2] = $urandom_range(1, 6);
					cfg[3] = $urandom_range(1, 3);
					cfg[4] = $urandom_range(0, 600);
					cfg[5] = $urandom_range(0, 600);
					cfg[6] = cfg[4] + $urandom_range(0, 3496);
					cfg[7] = cfg[5] + $urandom_range(0, 3496);
				end
			endcase
			write_regs(cfg);
			case (p % 4)
				0: begin snd_pct = 0;  rcv_pct = 0;  end
				1: begin snd_pct = 85; rcv_pct = 0;  end
				2: begin snd_pct = 0;  rcv_pct = 85; end
				default: begin snd_pct = 36; rcv_pct = 36; end
			endcase
			// one long receiver hold-off while words keep coming in
			if (p == 1) hold_req = 1'b1;
			n_phase = (p == 4) ? 8 : 30;
			for (int k = 0; k < n_phase; k++) begin
				r = $urandom_range(99);
				if (r < 70) begin
					w = rand_word(OP_DRAW);
					// a few glyphs per phase keep the bitmap loading short
					if (first_code <= last_code && $urandom_range(3) != 0)
						c = first_code + $urandom_range(0,
							(last_code - first_code > 3) ? 3 : last_code - first_code);
					else
						c = w.code;
					w.code = 8'(c);
					w.ns = ($urandom_range(99) < ((p == 7) ? 3 : 25));
					if ($urandom_range(1)) begin
						w.sx = 13'(clip_l + $urandom_range(0, 80) - 40);
						w.sy = 13'(clip_t + $urandom_range(0, 40) - 20);
					end
					if (c >= first_code && c <= last_code && !glyph_ready(c))
						define_glyph(c);
					send(w);
				end else if (r < 82) begin
					send(rand_word(OP_LOAD_MET));
				end else if (r < 94) begin
					send(rand_word(OP_LOAD_BMP));
				end else begin
					send(rand_word(OP_NOP));
				end
			end
		end

		itm.valid <= 1'b0;
		wait (rows_due.size() == 0);
		repeat (50) @(posedge clk);
		$display("run: %0d draw words, %0d load words, %0d result words checked",
			n_draw, n_load, n_rows);
		$display("     %0d metrics rejections seen, 8 register settings", n_err);
		if (fails == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== bitmap_glyph_blitter.f =====
rtl/core/bgb_pkg.sv
rtl/core/bgb_ifs.sv
rtl/core/bgb_ram.sv
rtl/core/bitmap_glyph_blitter.sv
bench/tb_top.sv
